@@ design/nnvr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the nearest-neighbor routing block.
// Used by the square-root cells, the cell chain and the top level.
package nnvr_pkg;

    localparam int MAX_CUSTOMERS = 32;
    localparam int IDX_W  = $clog2(MAX_CUSTOMERS);
    localparam int CNT_W  = $clog2(MAX_CUSTOMERS + 1);
    localparam int SQ_STEPS = 18;
    localparam int RAD_W  = 2 * SQ_STEPS;
    localparam int ROOT_W = SQ_STEPS;
    localparam int REM_W  = ROOT_W + 3;

    typedef enum logic [1:0] {
        OP_DEPOT = 2'd0,
        OP_CUST  = 2'd1,
        OP_SOLVE = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Tag carried with each customer through the distance pipeline.
    typedef struct packed {
        logic             vld;
        logic             last;
        logic             elig;
        logic [IDX_W-1:0] idx;
    } t_tag;

    // Contents of one square-root cell.
    typedef struct packed {
        t_tag              tag;
        logic [RAD_W-1:0]  rad;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
    } t_cell;

endpackage

@@ design/nnvr_sqrt_cell.sv @@
`timescale 1ns / 1ps
// One cell of the integer square-root chain: settles one root bit per cycle.
// Depends on nnvr_pkg for the cell record.
module nnvr_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  nnvr_pkg::t_cell i_cell,
    output nnvr_pkg::t_cell o_cell
);
    import nnvr_pkg::*;

    t_cell            r_cell;
    t_cell            n_cell;
    logic [REM_W-1:0] w_rem_s;
    logic [REM_W-1:0] w_trial;

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
        w_rem_s = {i_cell.rem[REM_W-3:0], i_cell.rad[RAD_W-1 -: 2]};
        w_trial = {1'b0, i_cell.root, 2'b01};
        n_cell = i_cell;
        n_cell.rad = {i_cell.rad[RAD_W-3:0], 2'b00};
        if (w_rem_s >= w_trial) begin
            n_cell.rem  = w_rem_s - w_trial;
            n_cell.root = {i_cell.root[ROOT_W-2:0], 1'b1};
        end else begin
            n_cell.rem  = w_rem_s;
            n_cell.root = {i_cell.root[ROOT_W-2:0], 1'b0};
        end
    end

    // Hand the result to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.tag <= '0;
        end else begin
            r_cell.tag <= n_cell.tag;
        end
        r_cell.rad  <= n_cell.rad;
        r_cell.root <= n_cell.root;
        r_cell.rem  <= n_cell.rem;
    end

    assign o_cell = r_cell;

endmodule

@@ design/nnvr_sqrt_chain.sv @@
`timescale 1ns / 1ps
// Row of square-root cells; one root bit per cell, one customer per cycle.
// Depends on nnvr_pkg and nnvr_sqrt_cell.
module nnvr_sqrt_chain (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  nnvr_pkg::t_cell i_cell,
    output nnvr_pkg::t_cell o_cell
);
    import nnvr_pkg::*;

    t_cell w_link [0:SQ_STEPS];

    assign w_link[0] = i_cell;

    // Each cell feeds its right-hand neighbor.
    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_cell
        nnvr_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (w_link[g]),
            .o_cell  (w_link[g+1])
        );
    end

    assign o_cell = w_link[SQ_STEPS];

endmodule

@@ design/nearest_neighbor_vehicle_routing.sv @@
`timescale 1ns / 1ps
// Greedy nearest-neighbor capacitated routing.
// A solve streams all n loaded customers through a 4-stage distance front end and an
// 18-cell square-root chain once per visit, once per route close and once for a closing
// scan, then checks each customer in turn for the unservable pass and finishes.
// Results are one-cycle strobes that cannot be held off; busy stays high for the whole solve.
// Synchronous active-low reset empties the store and clears depot, capacity and control.
module nearest_neighbor_vehicle_routing (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_customer_id,
    input  logic signed [15:0] i_x_coord,
    input  logic signed [15:0] i_y_coord,
    input  logic [15:0] i_demand,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_strobe,
    output logic [15:0] o_visited_id,
    output logic [6:0]  o_route_number,
    output logic        o_route_end,
    output logic        o_unservable,
    output logic        o_overflow_seen,
    output logic        o_last_result
);
    import nnvr_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SCAN   = 8'b0000_0010,
        S_DRAIN  = 8'b0000_0100,
        S_FETCH  = 8'b0000_1000,
        S_COMMIT = 8'b0001_0000,
        S_ULOOK  = 8'b0010_0000,
        S_UCHK   = 8'b0100_0000,
        S_FINAL  = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic [15:0] id;
        logic [6:0]  route;
        logic        rend;
        logic        unserv;
    } t_res;

    t_state             r_state;
    logic [15:0]        r_cap;
    logic [CNT_W-1:0]   r_count;
    logic               r_dropped;
    logic signed [15:0] r_depot_x;
    logic signed [15:0] r_depot_y;
    logic signed [15:0] r_cx;
    logic signed [15:0] r_cy;
    logic [15:0]        r_rem;
    logic [6:0]         r_route;
    logic               r_has_visit;
    logic [MAX_CUSTOMERS-1:0] r_served;
    logic [IDX_W-1:0]   r_scan_idx;
    logic               r_scan_done;
    logic               r_found;
    logic [ROOT_W-1:0]  r_best_d;
    logic [IDX_W-1:0]   r_best_idx;
    t_res               r_hold;
    logic               r_hold_vld;

    // Customer store: id, x, y, demand in one word.
    logic [63:0]        r_mem [0:MAX_CUSTOMERS-1];
    logic [63:0]        r_rd;
    logic [IDX_W-1:0]   w_rd_addr;
    logic               w_wr_en;

    // Distance front end.
    t_tag               r_p1;
    t_tag               r_p2;
    logic signed [16:0] r_dx;
    logic signed [16:0] r_dy;
    t_tag               r_p3;
    logic [33:0]        r_sqx;
    logic [33:0]        r_sqy;
    t_cell              r_p4;
    t_cell              w_chain;
    logic signed [33:0] w_mx;
    logic signed [33:0] w_my;

    // Output register.
    logic               r_strobe;
    t_res               r_out;
    logic               r_out_ovf;
    logic               r_out_last;

    logic [15:0]        w_rd_id;
    logic signed [15:0] w_rd_x;
    logic signed [15:0] w_rd_y;
    logic [15:0]        w_rd_dem;
    logic               w_accept;
    logic               w_scan_last;
    logic               w_better;

    assign w_rd_id  = r_rd[63:48];
    assign w_rd_x   = r_rd[47:32];
    assign w_rd_y   = r_rd[31:16];
    assign w_rd_dem = r_rd[15:0];
    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_wr_en  = w_accept && (t_op'(i_operation) == OP_CUST)
                      && (r_count < CNT_W'(MAX_CUSTOMERS));
    assign w_scan_last = ({1'b0, r_scan_idx} == (r_count - CNT_W'(1)));

    // Read address of the single store read port.
    always_comb begin
        case (r_state)
            S_SCAN:  w_rd_addr = r_scan_idx;
            S_FETCH: w_rd_addr = r_best_idx;
            default: w_rd_addr = r_scan_idx;
        endcase
    end

    // Store write and registered read.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= {i_customer_id, i_x_coord, i_y_coord, i_demand};
        end
        r_rd <= r_mem[w_rd_addr];
    end

    // Front end: offsets, squares, sum into the root chain.
    assign w_mx = r_dx * r_dx;
    assign w_my = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= '0;
            r_p2 <= '0;
            r_p3 <= '0;
            r_p4.tag <= '0;
        end else begin
            r_p1.vld  <= (r_state == S_SCAN);
            r_p1.last <= w_scan_last;
            r_p1.elig <= 1'b0;
            r_p1.idx  <= r_scan_idx;
            r_p2.vld  <= r_p1.vld;
            r_p2.last <= r_p1.last;
            r_p2.idx  <= r_p1.idx;
            r_p2.elig <= !r_served[r_p1.idx] && (w_rd_dem <= r_rem);
            r_p3      <= r_p2;
            r_p4.tag  <= r_p3;
        end
        r_dx  <= 17'({w_rd_x[15], w_rd_x}) - 17'({r_cx[15], r_cx});
        r_dy  <= 17'({w_rd_y[15], w_rd_y}) - 17'({r_cy[15], r_cy});
        r_sqx <= 34'(w_mx);
        r_sqy <= 34'(w_my);
        r_p4.rad  <= RAD_W'({1'b0, r_sqx} + {1'b0, r_sqy});
        r_p4.root <= '0;
        r_p4.rem  <= '0;
    end

    nnvr_sqrt_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (r_p4),
        .o_cell  (w_chain)
    );

    assign w_better = w_chain.tag.vld && w_chain.tag.elig
                      && (!r_found || (w_chain.root < r_best_d));

    // Control sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= '0;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_depot_x   <= '0;
            r_depot_y   <= '0;
            r_served    <= '0;
            r_hold_vld  <= 1'b0;
            r_strobe    <= 1'b0;
            r_scan_done <= 1'b0;
            r_found     <= 1'b0;
            r_scan_idx  <= '0;
            r_has_visit <= 1'b0;
            r_route     <= '0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            // Best-candidate tracking at the end of the chain.
            if (w_better) begin
                r_found    <= 1'b1;
                r_best_d   <= w_chain.root;
                r_best_idx <= w_chain.tag.idx;
            end
            if (w_chain.tag.vld && w_chain.tag.last) begin
                r_scan_done <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (t_op'(i_operation))
                            OP_DEPOT: begin
                                r_depot_x <= i_x_coord;
                                r_depot_y <= i_y_coord;
                            end
                            OP_CUST: begin
                                if (r_count < CNT_W'(MAX_CUSTOMERS)) begin
                                    r_count <= r_count + CNT_W'(1);
                                end else begin
                                    r_dropped <= 1'b1;
                                end
                            end
                            OP_SOLVE: begin
                                r_route     <= '0;
                                r_has_visit <= 1'b0;
                                r_rem       <= r_cap;
                                r_cx        <= r_depot_x;
                                r_cy        <= r_depot_y;
                                r_hold_vld  <= 1'b0;
                                r_scan_idx  <= '0;
                                r_found     <= 1'b0;
                                r_scan_done <= 1'b0;
                                r_state     <= (r_count == '0) ? S_FINAL : S_SCAN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_scan_idx <= r_scan_idx + IDX_W'(1);
                    if (w_scan_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_scan_done) begin
                        r_scan_idx  <= '0;
                        r_scan_done <= 1'b0;
                        if (r_found) begin
                            r_state <= S_FETCH;
                        end else if (r_has_visit) begin
                            // Route closes; start a fresh vehicle at the depot.
                            r_hold.rend <= 1'b1;
                            r_route     <= r_route + 7'd1;
                            r_has_visit <= 1'b0;
                            r_rem       <= r_cap;
                            r_cx        <= r_depot_x;
                            r_cy        <= r_depot_y;
                            r_state     <= S_SCAN;
                        end else begin
                            r_state <= S_ULOOK;
                        end
                    end
                end
                S_FETCH: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    r_strobe     <= r_hold_vld;
                    r_out        <= r_hold;
                    r_out_ovf    <= r_dropped;
                    r_out_last   <= 1'b0;
                    r_hold       <= '{id: w_rd_id, route: r_route, rend: 1'b0, unserv: 1'b0};
                    r_hold_vld   <= 1'b1;
                    r_served[r_best_idx] <= 1'b1;
                    r_rem        <= r_rem - w_rd_dem;
                    r_cx         <= w_rd_x;
                    r_cy         <= w_rd_y;
                    r_has_visit  <= 1'b1;
                    r_found      <= 1'b0;
                    r_scan_idx   <= '0;
                    r_state      <= S_SCAN;
                end
                S_ULOOK: begin
                    r_state <= S_UCHK;
                end
                S_UCHK: begin
                    // Customers that never fit a vehicle go out in load order.
                    if (w_rd_dem > r_cap) begin
                        r_strobe   <= r_hold_vld;
                        r_out      <= r_hold;
                        r_out_ovf  <= r_dropped;
                        r_out_last <= 1'b0;
                        r_hold     <= '{id: w_rd_id, route: 7'd0, rend: 1'b0, unserv: 1'b1};
                        r_hold_vld <= 1'b1;
                    end
                    r_scan_idx <= r_scan_idx + IDX_W'(1);
                    r_state    <= w_scan_last ? S_FINAL : S_ULOOK;
                end
                S_FINAL: begin
                    r_strobe   <= r_hold_vld;
                    r_out      <= r_hold;
                    r_out_ovf  <= r_dropped;
                    r_out_last <= 1'b1;
                    r_hold_vld <= 1'b0;
                    r_count    <= '0;
                    r_dropped  <= 1'b0;
                    r_served   <= '0;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_visited_id    = r_out.id;
    assign o_route_number  = r_out.route;
    assign o_route_end     = r_out.rend;
    assign o_unservable    = r_out.unserv;
    assign o_overflow_seen = r_out_ovf;
    assign o_last_result   = r_out_last;

endmodule
